FILE: sv/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define AST_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication checked at every clock edge outside reset.
`define AST_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

FILE: sv/ptae_pkg.sv
`default_nettype none
package ptae_pkg;

  localparam int CapacityDef = 16;
  localparam logic [7:0] UnknownSig = 8'h81;  // -127

  typedef enum logic [2:0] {
    OP_HELLO = 3'd0,
    OP_NEAR  = 3'd1,
    OP_PRUNE = 3'd2,
    OP_LOOK  = 3'd3,
    OP_ACK   = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    ST_MERGED  = 3'd0,
    ST_INSERT  = 3'd1,
    ST_EVICTED = 3'd2,
    ST_FOUND   = 3'd3,
    ST_MISS    = 3'd4,
    ST_ACKED   = 3'd5,
    ST_PRUNED  = 3'd6
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SRCH_RD,
    S_SRCH_CHK,
    S_EV_RD,
    S_EV_CHK,
    S_MV_RD,
    S_MV_WR,
    S_INS,
    S_PR_RD,
    S_PR_CHK,
    S_OUT
  } fsm_e;

  typedef struct packed {
    logic [47:0] key;
    logic [31:0] near_t;
    logic [31:0] mesh_t;
    logic [7:0]  near_sig;
    logic [7:0]  mesh_sig;
    logic [31:0] fw;
    logic [7:0]  proto;
    logic [7:0]  ust;
    logic        ack;
  } entry_t;

  function automatic logic [31:0] last_seen(input entry_t e);
    return (e.near_t > e.mesh_t) ? e.near_t : e.mesh_t;
  endfunction

endpackage
`default_nettype wire

FILE: sv/peer_table_with_aging_and_eviction_core.sv
// Each entry searched takes one memory read and one compare. A full-table insert
// adds an oldest-entry scan (a read and a compare per entry) and a move (the last
// entry is read and fills the hole). Prune reads and tests each entry, and each
// removal adds a move. One item at a time; the entry memory's single read port sets
// the pace. Reset empties the table and clears the generation counter at once.
`default_nettype none
`include "assert_macros.svh"

module peer_table_with_aging_and_eviction_core
  import ptae_pkg::*;
#(
  parameter int CAPACITY = CapacityDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [2:0]         op_i,
  input  wire logic [47:0]        peer_addr_i,
  input  wire logic [31:0]        now_ms_i,
  input  wire logic signed [7:0]  signal_dbm_i,
  input  wire logic [31:0]        fw_version_i,
  input  wire logic [7:0]         proto_version_i,
  input  wire logic [7:0]         update_state_i,
  input  wire logic [31:0]        max_age_ms_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [2:0]              status_o,
  output logic [4:0]              entry_count_o,
  output logic [31:0]             change_count_o,
  output logic [4:0]              removed_count_o,
  output logic [47:0]             entry_addr_o,
  output logic [31:0]             entry_fw_o,
  output logic [7:0]              entry_proto_o,
  output logic [7:0]              entry_update_state_o,
  output logic signed [7:0]       entry_near_signal_o,
  output logic signed [7:0]       entry_mesh_signal_o,
  output logic                    entry_acked_o,
  output logic [31:0]             entry_last_seen_o
);

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CapFull = CW'(CAPACITY);

  // Entry memory, one synchronous read port and one write port
  entry_t mem [CAPACITY];

  fsm_e state_q, state_d;

  // Item payload
  logic [2:0]  op_q;
  logic [47:0] addr_q;
  logic [31:0] now_q, fw_q, age_q;
  logic [7:0]  sig_q, proto_q, ust_q;

  // Control state
  logic [CW-1:0] idx_q, idx_d, fill_q, fill_d, removed_q, removed_d, best_q, best_d;
  logic [31:0]   gen_q, gen_d, best_t_q, best_t_d;
  status_e       status_q, status_d;
  entry_t        rd_q;

  // Output register
  logic          out_valid_q;
  status_e       o_status_q;
  logic [4:0]    o_count_q, o_removed_q;
  logic [31:0]   o_gen_q;
  entry_t        o_entry_q;
  logic [31:0]   o_ls_q;

  // Memory access
  logic          rd_en, wr_en;
  logic [IW-1:0] rd_addr, wr_addr;
  entry_t        wr_data;

  // Scan helpers
  logic [CW-1:0] last_idx;
  logic          scan_end, key_hit, stale, out_free, is_ins;
  logic [31:0]   rd_ls;

  assign last_idx = fill_q - CW'(1);
  assign scan_end = (idx_q >= fill_q);
  assign rd_ls    = last_seen(rd_q);
  assign key_hit  = (rd_q.key == addr_q);
  assign stale    = (rd_ls != 32'd0) && ((now_q - rd_ls) > age_q);
  assign out_free = !out_valid_q || !out_stall_i;
  assign is_ins   = (op_q == OP_HELLO) || (op_q == OP_NEAR);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          case (op_i)
            OP_HELLO, OP_NEAR, OP_LOOK, OP_ACK: state_d = S_SRCH_RD;
            OP_PRUNE:                           state_d = S_PR_RD;
            default:                            state_d = S_IDLE;
          endcase
        end
      end
      S_SRCH_RD: begin
        if (!scan_end)            state_d = S_SRCH_CHK;
        else if (!is_ins)         state_d = S_OUT;
        else if (fill_q == CapFull) state_d = S_EV_RD;
        else                      state_d = S_INS;
      end
      S_SRCH_CHK: state_d = key_hit ? S_OUT : S_SRCH_RD;
      S_EV_RD:    state_d = scan_end ? S_MV_RD : S_EV_CHK;
      S_EV_CHK:   state_d = S_EV_RD;
      S_MV_RD:    state_d = S_MV_WR;
      S_MV_WR:    state_d = (op_q == OP_PRUNE) ? S_PR_RD : S_INS;
      S_INS:      state_d = S_OUT;
      S_PR_RD:    state_d = scan_end ? S_OUT : S_PR_CHK;
      S_PR_CHK:   state_d = stale ? S_MV_RD : S_PR_RD;
      S_OUT:      state_d = out_free ? S_IDLE : S_OUT;
      default:    state_d = S_IDLE;
    endcase
  end

  // Datapath and memory control
  always_comb begin
    idx_d     = idx_q;
    fill_d    = fill_q;
    removed_d = removed_q;
    best_d    = best_q;
    best_t_d  = best_t_q;
    gen_d     = gen_q;
    status_d  = status_q;
    rd_en     = 1'b0;
    rd_addr   = idx_q[IW-1:0];
    wr_en     = 1'b0;
    wr_addr   = idx_q[IW-1:0];
    wr_data   = rd_q;
    in_stall_o = (state_q != S_IDLE);
    case (state_q)
      S_IDLE: begin
        idx_d     = '0;
        removed_d = '0;
        status_d  = ST_PRUNED;
      end
      S_SRCH_RD: begin
        rd_en = !scan_end;
        if (scan_end) begin
          if (!is_ins) status_d = ST_MISS;
          else if (fill_q == CapFull) begin
            status_d = ST_EVICTED;
            idx_d    = '0;
          end else status_d = ST_INSERT;
        end
      end
      S_SRCH_CHK: begin
        if (key_hit) begin
          case (op_q)
            OP_HELLO: begin
              status_d = ST_MERGED;
              gen_d    = gen_q + 32'd1;
              wr_en    = 1'b1;
              wr_data.mesh_t = now_q;
              wr_data.ust    = ust_q;
              if (fw_q != 32'd0)      wr_data.fw       = fw_q;
              if (proto_q != 8'd0)    wr_data.proto    = proto_q;
              if (sig_q != UnknownSig) wr_data.mesh_sig = sig_q;
            end
            OP_NEAR: begin
              status_d = ST_MERGED;
              gen_d    = gen_q + 32'd1;
              wr_en    = 1'b1;
              wr_data.near_t = now_q;
              if (sig_q != UnknownSig) wr_data.near_sig = sig_q;
            end
            OP_ACK: begin
              status_d    = ST_ACKED;
              gen_d       = gen_q + 32'd1;
              wr_en       = 1'b1;
              wr_data.ack = 1'b1;
            end
            default: status_d = ST_FOUND;
          endcase
        end else idx_d = idx_q + CW'(1);
      end
      S_EV_RD: begin
        rd_en = !scan_end;
        if (scan_end) idx_d = best_q;
      end
      S_EV_CHK: begin
        // strict compare keeps the lowest slot on ties
        if (idx_q == '0 || rd_ls < best_t_q) begin
          best_d   = idx_q;
          best_t_d = rd_ls;
        end
        idx_d = idx_q + CW'(1);
      end
      S_MV_RD: begin
        rd_en   = 1'b1;
        rd_addr = last_idx[IW-1:0];
      end
      S_MV_WR: begin
        // last entry fills the hole
        wr_en  = (idx_q != last_idx);
        fill_d = last_idx;
        if (op_q == OP_PRUNE) begin
          gen_d     = gen_q + 32'd1;
          removed_d = removed_q + CW'(1);
        end
      end
      S_INS: begin
        wr_en   = 1'b1;
        wr_addr = fill_q[IW-1:0];
        wr_data = '{key: addr_q, near_t: 32'd0, mesh_t: 32'd0, near_sig: UnknownSig,
                    mesh_sig: UnknownSig, fw: 32'd0, proto: 8'd0, ust: 8'd0, ack: 1'b0};
        if (op_q == OP_HELLO) begin
          wr_data.mesh_t   = now_q;
          wr_data.mesh_sig = sig_q;
          wr_data.fw       = fw_q;
          wr_data.proto    = proto_q;
          wr_data.ust      = ust_q;
        end else begin
          wr_data.near_t   = now_q;
          wr_data.near_sig = sig_q;
        end
        fill_d = fill_q + CW'(1);
        gen_d  = gen_q + 32'd1;
      end
      S_PR_RD: rd_en = !scan_end;
      S_PR_CHK: begin
        if (!stale) idx_d = idx_q + CW'(1);
      end
      default: ;
    endcase
  end

  // Memory
  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_q <= mem[rd_addr];
  end

  // Item payload capture
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i) begin
      op_q    <= op_i;
      addr_q  <= peer_addr_i;
      now_q   <= now_ms_i;
      sig_q   <= signal_dbm_i;
      fw_q    <= fw_version_i;
      proto_q <= proto_version_i;
      ust_q   <= update_state_i;
      age_q   <= max_age_ms_i;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      idx_q     <= '0;
      fill_q    <= '0;
      removed_q <= '0;
      best_q    <= '0;
      best_t_q  <= '0;
      gen_q     <= '0;
      status_q  <= ST_MERGED;
    end else begin
      state_q   <= state_d;
      idx_q     <= idx_d;
      fill_q    <= fill_d;
      removed_q <= removed_d;
      best_q    <= best_d;
      best_t_q  <= best_t_d;
      gen_q     <= gen_d;
      status_q  <= status_d;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == S_OUT && out_free) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_OUT && out_free) begin
      o_status_q  <= status_q;
      o_count_q   <= 5'(fill_q);
      o_gen_q     <= gen_q;
      o_removed_q <= 5'(removed_q);
      o_entry_q   <= (status_q == ST_FOUND) ? rd_q : '0;
      o_ls_q      <= (status_q == ST_FOUND) ? rd_ls : 32'd0;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign status_o             = o_status_q;
  assign entry_count_o        = o_count_q;
  assign change_count_o       = o_gen_q;
  assign removed_count_o      = o_removed_q;
  assign entry_addr_o         = o_entry_q.key;
  assign entry_fw_o           = o_entry_q.fw;
  assign entry_proto_o        = o_entry_q.proto;
  assign entry_update_state_o = o_entry_q.ust;
  assign entry_near_signal_o  = $signed(o_entry_q.near_sig);
  assign entry_mesh_signal_o  = $signed(o_entry_q.mesh_sig);
  assign entry_acked_o        = o_entry_q.ack;
  assign entry_last_seen_o    = o_ls_q;

  // Checks
  `AST_ALWAYS(a_fill_bound, fill_q <= CapFull, "fill count above capacity")
  `AST_IMPLY(a_prune_gen, state_q == S_MV_WR && op_q == OP_PRUNE,
             ##1 gen_q == $past(gen_q) + 32'd1, "prune removal missed generation")
  `AST_IMPLY(a_out_src, $rose(out_valid_q), $past(state_q) == S_OUT,
             "result raised outside output state")
  `AST_IMPLY(a_ins_room, state_q == S_INS, fill_q < CapFull, "insert into full table")

endmodule
`default_nettype wire

FILE: tb/sv/peer_table_with_aging_and_eviction_core_chk.sv
`default_nettype none
module peer_table_with_aging_and_eviction_core_chk
  import ptae_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire logic              in_stall_i,
  input  wire logic [2:0]        op_i,
  input  wire logic [47:0]       peer_addr_i,
  input  wire logic [31:0]       now_ms_i,
  input  wire logic signed [7:0] signal_dbm_i,
  input  wire logic [31:0]       fw_version_i,
  input  wire logic [7:0]        proto_version_i,
  input  wire logic [7:0]        update_state_i,
  input  wire logic [31:0]       max_age_ms_i,
  input  wire logic              out_valid_i,
  input  wire logic              out_stall_i,
  input  wire logic [2:0]        status_i,
  input  wire logic [4:0]        entry_count_i,
  input  wire logic [31:0]       change_count_i,
  input  wire logic [4:0]        removed_count_i,
  input  wire logic [47:0]       entry_addr_i,
  input  wire logic [31:0]       entry_fw_i,
  input  wire logic [7:0]        entry_proto_i,
  input  wire logic [7:0]        entry_update_state_i,
  input  wire logic signed [7:0] entry_near_signal_i,
  input  wire logic signed [7:0] entry_mesh_signal_i,
  input  wire logic              entry_acked_i,
  input  wire logic [31:0]       entry_last_seen_i,
  output int                     fail_count_o,
  output int                     pending_o,
  output int                     result_count_o,
  output int                     evict_count_o,
  output int                     pruned_total_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Depth = 16;

  typedef struct packed {
    logic [2:0]  status;
    logic [4:0]  count;
    logic [31:0] gen;
    logic [4:0]  removed;
    logic [47:0] addr;
    logic [31:0] fw;
    logic [7:0]  proto;
    logic [7:0]  ust;
    logic [7:0]  near_sig;
    logic [7:0]  mesh_sig;
    logic        ack;
    logic [31:0] seen;
  } reply_t;

  // shadow copy of the peer table
  entry_t      peers[Depth];
  int          peer_fill;
  logic [31:0] peer_gen;
  reply_t      reply_q[$];

  function automatic logic [31:0] seen_of(int i);
    return (peers[i].near_t > peers[i].mesh_t) ? peers[i].near_t : peers[i].mesh_t;
  endfunction

  function automatic int slot_of(logic [47:0] a);
    for (int i = 0; i < peer_fill; i++) if (peers[i].key == a) return i;
    return peer_fill;
  endfunction

  // compaction: last entry moves into the hole
  task automatic drop_slot(int i);
    if (i != peer_fill - 1) peers[i] = peers[peer_fill - 1];
    peer_fill--;
  endtask

  task automatic update_table(logic [2:0] op, logic [47:0] a, logic [31:0] now,
                              logic [7:0] sig, logic [31:0] fw, logic [7:0] pv,
                              logic [7:0] us, logic [31:0] age);
    reply_t r;
    int s, oldest;
    logic [31:0] t;
    r = '0;
    if (op == OP_HELLO || op == OP_NEAR) begin
      s = slot_of(a);
      if (s == peer_fill) begin
        r.status = ST_INSERT;
        if (peer_fill == Depth) begin
          oldest = 0;
          for (int i = 1; i < peer_fill; i++) if (seen_of(i) < seen_of(oldest)) oldest = i;
          drop_slot(oldest);
          r.status = ST_EVICTED;
          evict_count_o++;
        end
        s = peer_fill;
        peers[s] = '0;
        peers[s].key = a;
        peers[s].near_sig = UnknownSig;
        peers[s].mesh_sig = UnknownSig;
        if (op == OP_HELLO) begin
          peers[s].mesh_t = now;
          peers[s].mesh_sig = sig;
          peers[s].fw = fw;
          peers[s].proto = pv;
          peers[s].ust = us;
        end else begin
          peers[s].near_t = now;
          peers[s].near_sig = sig;
        end
        peer_fill++;
      end else if (op == OP_HELLO) begin
        r.status = ST_MERGED;
        peers[s].mesh_t = now;
        if (fw != 0) peers[s].fw = fw;
        peers[s].ust = us;
        if (pv != 0) peers[s].proto = pv;
        if (sig != UnknownSig) peers[s].mesh_sig = sig;
      end else begin
        r.status = ST_MERGED;
        peers[s].near_t = now;
        if (sig != UnknownSig) peers[s].near_sig = sig;
      end
      peer_gen++;
    end else if (op == OP_PRUNE) begin
      r.status = ST_PRUNED;
      s = 0;
      while (s < peer_fill) begin
        t = seen_of(s);
        if (t != 0 && (now - t) > age) begin
          drop_slot(s);
          peer_gen++;
          r.removed++;
          pruned_total_o++;
        end else s++;
      end
    end else if (op == OP_LOOK) begin
      s = slot_of(a);
      if (s < peer_fill) begin
        r.status = ST_FOUND;
        r.addr = peers[s].key;
        r.fw = peers[s].fw;
        r.proto = peers[s].proto;
        r.ust = peers[s].ust;
        r.near_sig = peers[s].near_sig;
        r.mesh_sig = peers[s].mesh_sig;
        r.ack = peers[s].ack;
        r.seen = seen_of(s);
      end else r.status = ST_MISS;
    end else if (op == OP_ACK) begin
      s = slot_of(a);
      if (s < peer_fill) begin
        peers[s].ack = 1'b1;
        peer_gen++;
        r.status = ST_ACKED;
      end else r.status = ST_MISS;
    end else return;  // unknown op: no reply
    r.count = 5'(peer_fill);
    r.gen = peer_gen;
    reply_q.insert(reply_q.size(), r);
  endtask

  function automatic void cmp(string nm, logic [63:0] e, logic [63:0] a);
    if (e !== a) begin
      $display("%0t %s: expected %0h actual %0h", $time, nm, e, a);
      fail_count_o++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    reply_t e;
    if (!rst_ni) begin
      peer_fill = 0;
      peer_gen = '0;
      reply_q.delete();
      fail_count_o = 0;
      result_count_o = 0;
      evict_count_o = 0;
      pruned_total_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        result_count_o++;
        if (reply_q.size() == 0) begin
          $display("%0t unexpected result: status %0d", $time, status_i);
          fail_count_o++;
        end else begin
          e = reply_q.pop_front();
          cmp("status", e.status, status_i);
          cmp("entry_count", e.count, entry_count_i);
          cmp("change_count", e.gen, change_count_i);
          cmp("removed_count", e.removed, removed_count_i);
          cmp("entry_addr", e.addr, entry_addr_i);
          cmp("entry_fw", e.fw, entry_fw_i);
          cmp("entry_proto", e.proto, entry_proto_i);
          cmp("entry_update_state", e.ust, entry_update_state_i);
          cmp("entry_near_signal", e.near_sig, $unsigned(entry_near_signal_i));
          cmp("entry_mesh_signal", e.mesh_sig, $unsigned(entry_mesh_signal_i));
          cmp("entry_acked", e.ack, entry_acked_i);
          cmp("entry_last_seen", e.seen, entry_last_seen_i);
        end
      end
      if (in_valid_i && !in_stall_i)
        update_table(op_i, peer_addr_i, now_ms_i, signal_dbm_i, fw_version_i,
                     proto_version_i, update_state_i, max_age_ms_i);
    end
    pending_o = reply_q.size();
  end
endmodule
`default_nettype wire

FILE: tb/sv/peer_table_with_aging_and_eviction_core_tb.sv
`default_nettype none
module peer_table_with_aging_and_eviction_core_tb;
  import ptae_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RandItems = 700;
  localparam int IdleLimit = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] op = '0;
  logic [47:0] peer_addr = '0;
  logic [31:0] now_ms = '0;
  logic signed [7:0] signal_dbm = '0;
  logic [31:0] fw_version = '0;
  logic [7:0] proto_version = '0;
  logic [7:0] update_state = '0;
  logic [31:0] max_age_ms = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [2:0] status;
  logic [4:0] entry_count, removed_count;
  logic [31:0] change_count, entry_fw, entry_last_seen;
  logic [47:0] entry_addr;
  logic [7:0] entry_proto, entry_update_state;
  logic signed [7:0] entry_near_signal, entry_mesh_signal;
  logic entry_acked;
  int fails, pending, results, evictions, pruned;
  int idle_cycles = 0;
  logic [47:0] known_addr[8];
  logic [31:0] clock_ms = 32'd1000;

  always #10 clk_i = ~clk_i;

  peer_table_with_aging_and_eviction_core u_top (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .op_i(op), .peer_addr_i(peer_addr), .now_ms_i(now_ms), .signal_dbm_i(signal_dbm),
    .fw_version_i(fw_version), .proto_version_i(proto_version),
    .update_state_i(update_state), .max_age_ms_i(max_age_ms),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .status_o(status), .entry_count_o(entry_count), .change_count_o(change_count),
    .removed_count_o(removed_count), .entry_addr_o(entry_addr), .entry_fw_o(entry_fw),
    .entry_proto_o(entry_proto), .entry_update_state_o(entry_update_state),
    .entry_near_signal_o(entry_near_signal), .entry_mesh_signal_o(entry_mesh_signal),
    .entry_acked_o(entry_acked), .entry_last_seen_o(entry_last_seen)
  );

  peer_table_with_aging_and_eviction_core_chk u_chk (
    .clk_i, .rst_ni, .in_valid_i(in_valid), .in_stall_i(in_stall),
    .op_i(op), .peer_addr_i(peer_addr), .now_ms_i(now_ms), .signal_dbm_i(signal_dbm),
    .fw_version_i(fw_version), .proto_version_i(proto_version),
    .update_state_i(update_state), .max_age_ms_i(max_age_ms),
    .out_valid_i(out_valid), .out_stall_i(out_stall),
    .status_i(status), .entry_count_i(entry_count), .change_count_i(change_count),
    .removed_count_i(removed_count), .entry_addr_i(entry_addr), .entry_fw_i(entry_fw),
    .entry_proto_i(entry_proto), .entry_update_state_i(entry_update_state),
    .entry_near_signal_i(entry_near_signal), .entry_mesh_signal_i(entry_mesh_signal),
    .entry_acked_i(entry_acked), .entry_last_seen_i(entry_last_seen),
    .fail_count_o(fails), .pending_o(pending), .result_count_o(results),
    .evict_count_o(evictions), .pruned_total_o(pruned)
  );

  function automatic int gap_len();
    if ($urandom_range(0, 2) == 0) return 0;
    return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 3);
  endfunction

  // receiver stall: random, with stall-free stretches
  always @(posedge clk_i) begin
    if ((results / 100) % 3 == 2) out_stall <= 1'b0;
    else if ($urandom_range(0, 15) == 0) out_stall <= ($urandom_range(0, 1) == 1);
    else out_stall <= ($urandom_range(0, 3) == 0);
  end

  // watchdog on accept activity
  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic send(logic [2:0] o, logic [47:0] a, logic [31:0] t, logic [7:0] s,
                      logic [31:0] fw, logic [7:0] pv, logic [7:0] us, logic [31:0] age,
                      bit gaps);
    int g;
    op <= o;
    peer_addr <= a;
    now_ms <= t;
    signal_dbm <= s;
    fw_version <= fw;
    proto_version <= pv;
    update_state <= us;
    max_age_ms <= age;
    in_valid <= 1'b1;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    g = gaps ? gap_len() : 0;
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  task automatic rand_item();
    int pick;
    logic [47:0] a;
    logic [2:0] o;
    logic [7:0] s;
    pick = $urandom_range(0, 99);
    a = ($urandom_range(0, 3) != 0) ? known_addr[$urandom_range(0, 7)] +
        48'($urandom_range(0, 20)) : 48'({$urandom(), $urandom()});
    if (pick < 35) o = OP_HELLO;
    else if (pick < 60) o = OP_NEAR;
    else if (pick < 68) o = OP_PRUNE;
    else if (pick < 84) o = OP_LOOK;
    else if (pick < 97) o = OP_ACK;
    else o = 3'($urandom_range(5, 7));
    clock_ms = clock_ms + $urandom_range(0, 400);
    s = ($urandom_range(0, 4) == 0) ? UnknownSig : 8'($urandom());
    send(o, a, ($urandom_range(0, 30) == 0) ? $urandom() : clock_ms, s,
         ($urandom_range(0, 2) == 0) ? 32'h0 : $urandom(),
         ($urandom_range(0, 2) == 0) ? 8'h0 : 8'($urandom()), 8'($urandom()),
         ($urandom_range(0, 5) == 0) ? $urandom() : $urandom_range(0, 3000), 1'b1);
  endtask

  initial begin
    for (int i = 0; i < 8; i++) known_addr[i] = 48'({$urandom(), $urandom()});
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty-table ops, extremes, merges with keep values
    send(OP_LOOK, 48'h0, 32'h0, 8'sh0, 32'h0, 8'h0, 8'h0, 32'h0, 1'b0);
    send(OP_ACK, 48'hFFFF_FFFF_FFFF, 32'h0, 8'sh0, 32'h0, 8'h0, 8'h0, 32'h0, 1'b1);
    send(OP_PRUNE, 48'h0, 32'hFFFF_FFFF, 8'sh0, 32'h0, 8'h0, 8'h0, 32'h0, 1'b0);
    send(OP_HELLO, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, UnknownSig, 32'hFFFF_FFFF, 8'hFF,
         8'hFF, 32'h0, 1'b0);
    send(OP_NEAR, 48'h0, 32'h0, 8'h80, 32'h0, 8'h0, 8'h0, 32'h0, 1'b0);
    send(OP_HELLO, 48'hFFFF_FFFF_FFFF, 32'h10, 8'h7F, 32'h0, 8'h0, 8'h00, 32'h0, 1'b0);
    send(OP_HELLO, 48'hFFFF_FFFF_FFFF, 32'h20, UnknownSig, 32'h0, 8'h0, 8'h5A, 32'h0, 1'b0);
    send(OP_NEAR, 48'hFFFF_FFFF_FFFF, 32'h30, UnknownSig, 32'h0, 8'h0, 8'h0, 32'h0, 1'b0);
    send(OP_ACK, 48'hFFFF_FFFF_FFFF, 32'h0, 8'h0, 32'h0, 8'h0, 8'h0, 32'h0, 1'b0);
    send(OP_LOOK, 48'hFFFF_FFFF_FFFF, 32'h0, 8'h0, 32'h0, 8'h0, 8'h0, 32'h0, 1'b0);
    send(OP_LOOK, 48'h0, 32'h0, 8'h0, 32'h0, 8'h0, 8'h0, 32'h0, 1'b0);
    send(3'd7, 48'h1, 32'h0, 8'h0, 32'h0, 8'h0, 8'h0, 32'h0, 1'b0);
    // fill past capacity with tied times: eviction picks lowest slot
    for (int i = 0; i < 17; i++)
      send(OP_HELLO, 48'h100 + 48'(i), 32'h40, 8'($urandom()), $urandom(), 8'h1, 8'h2,
           32'h0, 1'b1);
    // prune with wrapped age
    send(OP_PRUNE, 48'h0, 32'h8000_0000, 8'h0, 32'h0, 8'h0, 8'h0, 32'h100, 1'b0);
    send(OP_PRUNE, 48'h0, 32'h0, 8'h0, 32'h0, 8'h0, 8'h0, 32'hFFFF_FFFF, 1'b0);

    for (int n = 0; n < RandItems; n++) begin
      rand_item();
      // hold off until drained once in a while
      if (n % 200 == 100) begin
        in_valid <= 1'b0;
        @(posedge clk_i);
        while (pending != 0) @(posedge clk_i);
      end
    end
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    $display("covered %0d results, %0d evictions, %0d pruned entries, all five ops, merges",
             results, evictions, pruned);
    if (fails == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end
endmodule
`default_nettype wire
